/* sv/pmq_pkg.sv */
// Package for the per-destination message queues: sizes, command codes and item types.
package pmq_pkg;

  localparam int NUM_QUEUES  = 8;
  localparam int QUEUE_DEPTH = 512;

  localparam int HANDLE_W = 32;
  localparam int QIDX_W   = 3;
  localparam int COUNT_W  = 10;

  localparam int QSEL_W    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int POS_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W    = QSEL_W + POS_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef struct packed {
    logic                cmd;
    logic [QIDX_W-1:0]   queue_index;
    logic [HANDLE_W-1:0] message_handle;
  } req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] result_handle;
    logic                result_valid;
    logic                rejected_full;
    logic [COUNT_W-1:0]  queue_count;
    logic [COUNT_W-1:0]  high_water;
  } rsp_t;

endpackage

/* sv/per_destination_message_queues_unit.sv */
// Bank of per-destination circular handle FIFOs sharing one entry memory.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_valid/req_ready  | pmq_pkg::req_t (cmd, queue_index, message_handle)
//   rsp     | out | rsp_valid/rsp_ready  | pmq_pkg::rsp_t (handle, flags, count, high water)
//
// One item per cycle while req_ready is high; entry memory read and result stage load at
// the accepting edge, and the output register loads from the result stage when it advances.
// Queue pointers live in flops updated at accept, so back-to-back items to one queue
// see current pointers and the memory write/read order needs no forwarding.
// Reset clears pointers, counts and high-water marks; entry memory is not cleared.
// req_ready drops only while the result stage and the output register are both full
// and rsp_ready is low.
module per_destination_message_queues_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  pmq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output pmq_pkg::rsp_t rsp
);
  import pmq_pkg::*;

  logic [HANDLE_W-1:0] entry_store [MEM_DEPTH];
  logic [HANDLE_W-1:0] rdata;

  logic [POS_W-1:0] head_index  [NUM_QUEUES];
  logic [CNT_W-1:0] entry_count [NUM_QUEUES];
  logic [CNT_W-1:0] peak_count  [NUM_QUEUES];

  logic             s1_valid;
  logic             s1_deq_ok;
  logic             s1_full;
  logic [CNT_W-1:0] s1_count;
  logic [CNT_W-1:0] s1_peak;

  logic              accept;
  logic              advance;
  logic [QSEL_W-1:0] qsel;
  logic              in_range;
  logic [POS_W-1:0]  cur_head;
  logic [CNT_W-1:0]  cur_count;
  logic [CNT_W-1:0]  cur_peak;
  logic              is_full;
  logic              is_empty;
  logic              do_enq;
  logic              do_deq;
  logic [POS_W:0]    tail_sum;
  logic [POS_W-1:0]  tail_pos;
  logic [POS_W-1:0]  head_next;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  peak_next;

  assign qsel      = QSEL_W'(req.queue_index);
  assign in_range  = (32'(req.queue_index) < NUM_QUEUES);
  assign cur_head  = head_index[qsel];
  assign cur_count = entry_count[qsel];
  assign cur_peak  = peak_count[qsel];
  assign is_full   = (cur_count == CNT_W'(QUEUE_DEPTH));
  assign is_empty  = (cur_count == '0);
  assign do_enq    = in_range && (req.cmd == CMD_ENQ) && !is_full;
  assign do_deq    = in_range && (req.cmd == CMD_DEQ) && !is_empty;

  assign tail_sum = {1'b0, cur_head} + (POS_W+1)'(cur_count);
  assign tail_pos = (tail_sum >= (POS_W+1)'(QUEUE_DEPTH)) ?
                    POS_W'(tail_sum - (POS_W+1)'(QUEUE_DEPTH)) : POS_W'(tail_sum);
  assign head_next = (cur_head == POS_W'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;

  always_comb begin
    count_next = cur_count;
    if (do_enq) begin
      count_next = cur_count + 1'b1;
    end else if (do_deq) begin
      count_next = cur_count - 1'b1;
    end
    peak_next = (do_enq && (count_next > cur_peak)) ? count_next : cur_peak;
  end

  assign advance   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_index[i]  <= '0;
        entry_count[i] <= '0;
        peak_count[i]  <= '0;
      end
    end else if (accept && in_range) begin
      if (do_deq) begin
        head_index[qsel] <= head_next;
      end
      entry_count[qsel] <= count_next;
      peak_count[qsel]  <= peak_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && do_enq) begin
      entry_store[{qsel, tail_pos}] <= req.message_handle;
    end
    if (accept && do_deq) begin
      rdata <= entry_store[{qsel, cur_head}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_deq_ok <= do_deq;
      s1_full   <= in_range && (req.cmd == CMD_ENQ) && is_full;
      s1_count  <= in_range ? count_next : '0;
      s1_peak   <= in_range ? peak_next : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.result_handle <= s1_deq_ok ? rdata : '0;
      rsp.result_valid  <= s1_deq_ok;
      rsp.rejected_full <= s1_full;
      rsp.queue_count   <= COUNT_W'(s1_count);
      rsp.high_water    <= COUNT_W'(s1_peak);
    end
  end

  a_full_means_at_depth: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_full |-> s1_count == CNT_W'(QUEUE_DEPTH))
    else $error("rejected enqueue with queue not at capacity");

  a_peak_covers_count: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> s1_peak >= s1_count)
    else $error("high-water mark below count");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !(s1_deq_ok && s1_full))
    else $error("dequeue success and full rejection together");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted item did not reach result stage");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("pending result lost or changed");

endmodule
